>>> hw/rtl/rsme_pkg.sv
package rsme_pkg;

    // Command codes carried by every input word.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Operation kinds latched by a start word.
    localparam logic KIND_MOVS = 1'b0;
    localparam logic KIND_STOS = 1'b1;

    // Element size codes.
    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_WORD  = 2'd1;
    localparam logic [1:0] SIZE_DWORD = 2'd2;
    localparam logic [1:0] SIZE_RSVD  = 2'd3;

    localparam logic DIR_UP   = 1'b0;
    localparam logic DIR_DOWN = 1'b1;

    typedef struct packed {
        logic        command;
        logic        op_kind;
        logic [1:0]  size_code;
        logic        direction;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [31:0] repeat_count;
        logic [31:0] fill_value;
        logic [31:0] read_data;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  size;
        logic        dir;
        logic [31:0] src_ptr;
        logic [31:0] dst_ptr;
        logic [31:0] remaining;
        logic [31:0] fill;
    } arch_state_t;

    typedef struct packed {
        logic        write_valid;
        logic [31:0] write_address;
        logic [1:0]  write_size;
        logic [31:0] write_data;
        logic [31:0] next_read_address;
        logic [31:0] count_left;
        logic [31:0] dest_after;
        logic        done_res;
    } result_t;

    function automatic logic [31:0] elem_bytes(input logic [1:0] size);
        logic [31:0] n;
        case (size)
            SIZE_BYTE: n = 32'd1;
            SIZE_WORD: n = 32'd2;
            default:   n = 32'd4;
        endcase
        return n;
    endfunction

    function automatic logic [31:0] elem_mask(input logic [1:0] size);
        logic [31:0] m;
        case (size)
            SIZE_BYTE: m = 32'h0000_00FF;
            SIZE_WORD: m = 32'h0000_FFFF;
            default:   m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

>>> hw/rtl/rsme_in_stage.sv
module rsme_in_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rsme_pkg::item_t      s_item,
    input  logic                 advance,
    output logic                 item_valid,
    output rsme_pkg::item_t      item
);
    import rsme_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The register frees up in the same cycle its word moves on.
    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> hw/rtl/rsme_step.sv
module rsme_step (
    input  rsme_pkg::item_t       item,
    input  rsme_pkg::arch_state_t cur,
    output rsme_pkg::arch_state_t nxt,
    output rsme_pkg::result_t     res
);
    import rsme_pkg::*;

    logic [31:0] delta;
    logic [31:0] src_adv;
    logic [31:0] dst_adv;
    logic        active;

    assign delta   = elem_bytes(cur.size);
    assign src_adv = (cur.dir == DIR_DOWN) ? cur.src_ptr - delta : cur.src_ptr + delta;
    assign dst_adv = (cur.dir == DIR_DOWN) ? cur.dst_ptr - delta : cur.dst_ptr + delta;
    assign active  = (item.command == CMD_STEP) && (cur.remaining != 32'd0);

    always_comb begin
        nxt               = cur;
        res.write_valid   = 1'b0;
        res.write_address = 32'd0;
        res.write_size    = SIZE_BYTE;
        res.write_data    = 32'd0;
        if (item.command == CMD_START) begin
            nxt.kind      = item.op_kind;
            nxt.size      = (item.size_code == SIZE_RSVD) ? SIZE_DWORD : item.size_code;
            nxt.dir       = item.direction;
            nxt.src_ptr   = item.source_address;
            nxt.dst_ptr   = item.dest_address;
            nxt.remaining = item.repeat_count;
            nxt.fill      = item.fill_value;
        end else if (active) begin
            res.write_valid   = 1'b1;
            res.write_address = cur.dst_ptr;
            res.write_size    = cur.size;
            res.write_data    = ((cur.kind == KIND_STOS) ? cur.fill : item.read_data)
                                & elem_mask(cur.size);
            if (cur.kind == KIND_MOVS) begin
                nxt.src_ptr = src_adv;
            end
            nxt.dst_ptr   = dst_adv;
            nxt.remaining = cur.remaining - 32'd1;
        end
        res.next_read_address = nxt.src_ptr;
        res.count_left        = nxt.remaining;
        res.dest_after        = nxt.dst_ptr;
        res.done_res          = (nxt.remaining == 32'd0);
    end

endmodule

>>> hw/rtl/rep_string_move_store_engine.sv
// REP MOVS / REP STOS string engine. A start word (command 0) loads the
// operation, element size, direction flag, source and destination
// addresses, element count and fill value; each step word (command 1)
// brings the data read at the address reported as m_next_read_address by
// the previous result and produces one memory write of the element (the
// read data for a move, the fill value for a store, masked to the element
// size), then moves the destination and, for a move, the source address
// by the element size and decrements the count, which stops at zero.
// Every input word gives exactly one result word. The engine accepts one
// word per clock cycle, and each result passes through the input register
// and then the result register. The architectural state (pointers, count)
// is updated in the same cycle a word passes from the input register to
// the result register, so consecutive steps chain without bubbles; the
// only stall is back-pressure from m_ready. Reset needs no clearing pass.
module rep_string_move_store_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic        s_op_kind,
    input  logic [1:0]  s_size_code,
    input  logic        s_direction,
    input  logic [31:0] s_source_address,
    input  logic [31:0] s_dest_address,
    input  logic [31:0] s_repeat_count,
    input  logic [31:0] s_fill_value,
    input  logic [31:0] s_read_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_write_valid,
    output logic [31:0] m_write_address,
    output logic [1:0]  m_write_size,
    output logic [31:0] m_write_data,
    output logic [31:0] m_next_read_address,
    output logic [31:0] m_count_left,
    output logic [31:0] m_dest_after,
    output logic        m_done_res
);
    import rsme_pkg::*;

    item_t       s_item;
    item_t       item;
    logic        item_valid;
    logic        advance;
    arch_state_t state_reg;
    arch_state_t state_next;
    result_t     step_res;
    result_t     res_reg;
    logic        out_valid_reg;
    logic        out_valid_next;

    assign s_item.command        = s_command;
    assign s_item.op_kind        = s_op_kind;
    assign s_item.size_code      = s_size_code;
    assign s_item.direction      = s_direction;
    assign s_item.source_address = s_source_address;
    assign s_item.dest_address   = s_dest_address;
    assign s_item.repeat_count   = s_repeat_count;
    assign s_item.fill_value     = s_fill_value;
    assign s_item.read_data      = s_read_data;

    // A word leaves the input register when the result register is empty
    // or its word is being taken in this cycle.
    assign advance = item_valid && (!out_valid_reg || m_ready);

    rsme_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    rsme_step u_step (
        .item (item),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    // Architectural state commits only when its word moves to the output.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    assign out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= step_res;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_write_valid       = res_reg.write_valid;
    assign m_write_address     = res_reg.write_address;
    assign m_write_size        = res_reg.write_size;
    assign m_write_data        = res_reg.write_data;
    assign m_next_read_address = res_reg.next_read_address;
    assign m_count_left        = res_reg.count_left;
    assign m_dest_after        = res_reg.dest_after;
    assign m_done_res          = res_reg.done_res;

    // A step that finds work left takes exactly one element off the count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item.command == CMD_STEP && state_reg.remaining != 32'd0)
        |=> state_reg.remaining == $past(state_reg.remaining) - 32'd1)
        else $error("count did not decrement by one on an active step");

    // The stored element size never takes the reserved code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.size != SIZE_RSVD)
        else $error("reserved element size stored");

    // A result without a write carries zero address, size and data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_write_valid) |->
        (m_write_address == 32'd0 && m_write_data == 32'd0 && m_write_size == SIZE_BYTE))
        else $error("non-write result carries write fields");

    // Byte writes never carry data above the low byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_write_valid && m_write_size == SIZE_BYTE) |->
        m_write_data[31:8] == 24'd0)
        else $error("byte write data not masked");

endmodule

>>> test/rep_string_move_store_engine_test.sv
module rep_string_move_store_engine_test;

    import rsme_pkg::*;

    // The run is stopped here if it has not ended on its own.
    localparam int CYCLE_LIMIT = 200000;

    // The engine holds a word in its input register and then in its result
    // register. This is the settling time allowed at the end.
    localparam int SETTLE_CYCLES = 8;

    // These are the receiver back-pressure modes. Each one holds for a
    // random stretch of cycles.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic        s_command        = CMD_START;
    logic        s_op_kind        = KIND_MOVS;
    logic [1:0]  s_size_code      = SIZE_BYTE;
    logic        s_direction      = DIR_UP;
    logic [31:0] s_source_address = '0;
    logic [31:0] s_dest_address   = '0;
    logic [31:0] s_repeat_count   = '0;
    logic [31:0] s_fill_value     = '0;
    logic [31:0] s_read_data      = '0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic        m_write_valid;
    logic [31:0] m_write_address;
    logic [1:0]  m_write_size;
    logic [31:0] m_write_data;
    logic [31:0] m_next_read_address;
    logic [31:0] m_count_left;
    logic [31:0] m_dest_after;
    logic        m_done_res;

    // This is the engine state as the testbench tracks it. It moves forward
    // once for each accepted word, just as the hardware does.
    logic        eng_kind  = KIND_MOVS;
    logic [1:0]  eng_size  = SIZE_BYTE;
    logic        eng_dir   = DIR_UP;
    logic [31:0] eng_src   = '0;
    logic [31:0] eng_dst   = '0;
    logic [31:0] eng_left  = '0;
    logic [31:0] eng_fill  = '0;

    // These are the result words still owed by the engine, oldest first.
    result_t due_results[$];

    int mismatches  = 0;
    int cycle_count = 0;

    // The sender works in bursts. The burst length and the gap before the
    // next burst are drawn at random, and gaps can be switched off for a
    // whole phase.
    int burst_left     = 0;
    bit sender_gaps_on = 1'b1;

    rx_mode_t    rx_mode    = RX_OPEN;
    int          rx_span    = 0;
    logic [15:0] rx_pattern = 16'hFFFF;
    logic [3:0]  rx_tick    = '0;

    rep_string_move_store_engine i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_command           (s_command),
        .s_op_kind           (s_op_kind),
        .s_size_code         (s_size_code),
        .s_direction         (s_direction),
        .s_source_address    (s_source_address),
        .s_dest_address      (s_dest_address),
        .s_repeat_count      (s_repeat_count),
        .s_fill_value        (s_fill_value),
        .s_read_data         (s_read_data),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_write_valid       (m_write_valid),
        .m_write_address     (m_write_address),
        .m_write_size        (m_write_size),
        .m_write_data        (m_write_data),
        .m_next_read_address (m_next_read_address),
        .m_count_left        (m_count_left),
        .m_dest_after        (m_dest_after),
        .m_done_res          (m_done_res)
    );

    always #1 aclk = ~aclk;

    // This function computes the result word that the engine owes for one
    // input word, and it advances the tracked state. A start word only
    // loads the state. A step word writes one element while any count is
    // left. Once the count is zero, a step word leaves everything as it is.
    function automatic result_t compute_string_result(input item_t w);
        result_t     r;
        logic [31:0] nbytes;
        logic [31:0] mask;
        r = '0;
        if (w.command == CMD_START) begin
            eng_kind = w.op_kind;
            // The reserved size code behaves as a doubleword.
            eng_size = (w.size_code == SIZE_RSVD) ? SIZE_DWORD : w.size_code;
            eng_dir  = w.direction;
            eng_src  = w.source_address;
            eng_dst  = w.dest_address;
            eng_left = w.repeat_count;
            eng_fill = w.fill_value;
        end else if (eng_left != 32'd0) begin
            nbytes = 32'd1 << eng_size;
            mask   = (eng_size == SIZE_DWORD) ? 32'hFFFF_FFFF : ((32'd1 << (8 * nbytes)) - 1);
            r.write_valid   = 1'b1;
            r.write_address = eng_dst;
            r.write_size    = eng_size;
            r.write_data    = ((eng_kind == KIND_STOS) ? eng_fill : w.read_data) & mask;
            // A store never reads, so only a move advances the source.
            // Both pointers wrap modulo 2^32.
            if (eng_kind == KIND_MOVS) begin
                eng_src = (eng_dir == DIR_DOWN) ? eng_src - nbytes : eng_src + nbytes;
            end
            eng_dst  = (eng_dir == DIR_DOWN) ? eng_dst - nbytes : eng_dst + nbytes;
            eng_left = eng_left - 32'd1;
        end
        r.next_read_address = eng_src;
        r.count_left        = eng_left;
        r.dest_after        = eng_dst;
        r.done_res          = (eng_left == 32'd0);
        return r;
    endfunction

    // A start word puts random data in read_data, and a step word puts
    // random data in all the start fields. The engine must ignore those
    // fields, and the random data also makes every bit toggle.
    function automatic item_t make_start(input logic kind, input logic [1:0] size,
                                         input logic dir, input logic [31:0] src,
                                         input logic [31:0] dst, input logic [31:0] cnt,
                                         input logic [31:0] fill);
        item_t w;
        w.command        = CMD_START;
        w.op_kind        = kind;
        w.size_code      = size;
        w.direction      = dir;
        w.source_address = src;
        w.dest_address   = dst;
        w.repeat_count   = cnt;
        w.fill_value     = fill;
        w.read_data      = $urandom();
        return w;
    endfunction

    function automatic item_t make_step(input logic [31:0] data);
        item_t w;
        w.command        = CMD_STEP;
        w.op_kind        = 1'($urandom_range(0, 1));
        w.size_code      = 2'($urandom_range(0, 3));
        w.direction      = 1'($urandom_range(0, 1));
        w.source_address = $urandom();
        w.dest_address   = $urandom();
        w.repeat_count   = $urandom();
        w.fill_value     = $urandom();
        w.read_data      = data;
        return w;
    endfunction

    // This task sends one word. A new burst may start with a gap first.
    // Valid then stays high, with the payload held, until the engine takes
    // the word. s_ready is sampled just after the edge, so it still has
    // the value it had at the edge.
    task automatic send_word(input item_t w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = sender_gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid          <= 1'b1;
        s_command        <= w.command;
        s_op_kind        <= w.op_kind;
        s_size_code      <= w.size_code;
        s_direction      <= w.direction;
        s_source_address <= w.source_address;
        s_dest_address   <= w.dest_address;
        s_repeat_count   <= w.repeat_count;
        s_fill_value     <= w.fill_value;
        s_read_data      <= w.read_data;
        do @(posedge aclk); while (s_ready !== 1'b1);
        due_results.push_back(compute_string_result(w));
    endtask

    // The sender holds off until the engine has returned every result
    // it owes.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
    endtask

    // A step that comes straight after reset finds a count of zero. It
    // must report done and make no write.
    task automatic test_step_after_reset();
        send_word(make_step(32'hFFFF_FFFF));
    endtask

    // A byte move runs upward across the top of the address space, and a
    // step is sent after the count has run out.
    task automatic test_byte_move_wrap_up();
        send_word(make_start(KIND_MOVS, SIZE_BYTE, DIR_UP, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                             32'd3, 32'hFFFF_FFFF));
        send_word(make_step(32'hFFFF_FFFF));
        send_word(make_step(32'h0000_0000));
        send_word(make_step(32'hA5A5_A5A5));
        send_word(make_step(32'h5A5A_5A5A));
    endtask

    // A word store runs downward through address zero. The step data must
    // not reach the write, and the source address must not move.
    task automatic test_word_store_down();
        send_word(make_start(KIND_STOS, SIZE_WORD, DIR_DOWN, 32'h0000_0000, 32'h0000_0001,
                             32'd2, 32'hDEAD_BEEF));
        send_word(make_step($urandom()));
        send_word(make_step($urandom()));
    endtask

    // The reserved size code must behave as a doubleword on a move.
    task automatic test_reserved_size_move();
        send_word(make_start(KIND_MOVS, SIZE_RSVD, DIR_DOWN, 32'h0000_0010, 32'h0000_0020,
                             32'd2, 32'h0000_0000));
        send_word(make_step(32'h8000_0001));
        send_word(make_step(32'h7FFF_FFFE));
    endtask

    // A doubleword store starts from the largest count. It is abandoned by
    // a new start of zero count, which is then stepped once.
    task automatic test_count_extremes();
        send_word(make_start(KIND_STOS, SIZE_DWORD, DIR_UP, 32'hFFFF_FFFF, 32'hFFFF_FFFC,
                             32'hFFFF_FFFF, 32'h1234_5678));
        send_word(make_step($urandom()));
        send_word(make_step($urandom()));
        send_word(make_start(KIND_MOVS, SIZE_BYTE, DIR_UP, 32'h0, 32'h0, 32'h0, 32'h0));
        send_word(make_step(32'hFFFF_FFFF));
    endtask

    // Most of the random traffic is whole string operations. Each one is
    // a start word, then steps until the count runs out, with up to two
    // steps beyond it. Large counts are cut short by the next start. About
    // one pick in ten sends a single noise word, with every field random.
    task automatic test_random_strings(input int target, input bit gaps_on);
        int          sent;
        int          steps;
        logic [31:0] cnt;
        int          pick;
        item_t       w;
        sent = 0;
        sender_gaps_on = gaps_on;
        while (sent < target) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                w = make_step($urandom());
                w.command = 1'($urandom_range(0, 1));
                send_word(w);
                sent++;
            end else begin
                pick = $urandom_range(0, 9);
                cnt = (pick < 7) ? $urandom_range(0, 6) :
                      (pick < 9) ? $urandom_range(7, 40) : $urandom();
                send_word(make_start(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                     1'($urandom_range(0, 1)), $urandom(), $urandom(), cnt,
                                     $urandom()));
                sent++;
                steps = (cnt > 40) ? $urandom_range(1, 48) : cnt + $urandom_range(0, 2);
                repeat (steps) begin
                    send_word(make_step($urandom()));
                    sent++;
                end
            end
        end
        sender_gaps_on = 1'b1;
    endtask

    // This task compares one field. Every field is widened to 32 bits.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Each result word accepted at an edge is compared, field by field,
    // with the oldest word still owed.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (due_results.size() == 0) begin
                $error("result word with none owed: write_address %0h count_left %0h",
                       m_write_address, m_count_left);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("write_valid", 32'(want.write_valid), 32'(m_write_valid));
                check_field("write_address", want.write_address, m_write_address);
                check_field("write_size", 32'(want.write_size), 32'(m_write_size));
                check_field("write_data", want.write_data, m_write_data);
                check_field("next_read_address", want.next_read_address,
                            m_next_read_address);
                check_field("count_left", want.count_left, m_count_left);
                check_field("dest_after", want.dest_after, m_dest_after);
                check_field("done_res", 32'(want.done_res), 32'(m_done_res));
            end
        end
    end

    // The receiver moves between back-pressure modes. It can accept every
    // cycle, stall at random, follow a repeating 16-bit pattern, or
    // accept only now and then. The mode changes at random intervals, so
    // stalls land on every phase of the sender's bursts.
    always @(posedge aclk) begin
        if (rx_span == 0) begin
            rx_mode    = rx_mode_t'($urandom_range(0, 3));
            rx_span    = $urandom_range(20, 200);
            rx_pattern = 16'($urandom()) | 16'h0001;
        end
        rx_span--;
        rx_tick = rx_tick + 4'd1;
        case (rx_mode)
            RX_OPEN:    m_ready <= 1'b1;
            RX_RANDOM:  m_ready <= ($urandom_range(0, 99) >= 40);
            RX_PATTERN: m_ready <= rx_pattern[rx_tick];
            default:    m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // The watchdog ends a run that hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** rep_string_move_store_engine: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_step_after_reset();
        test_byte_move_wrap_up();
        test_word_store_down();
        test_reserved_size_move();
        test_count_extremes();

        // The random part runs in phases with different sender behavior.
        // The sender drains the engine completely between phases.
        wait_for_results();
        test_random_strings(150, 1'b1);
        wait_for_results();
        test_random_strings(150, 1'b0);
        wait_for_results();
        test_random_strings(300, 1'b1);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("** rep_string_move_store_engine: PASSED **");
        end else begin
            $display("** rep_string_move_store_engine: FAILED **");
        end
        $finish;
    end

endmodule
